### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the lookup core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// explicit clock and reset
`define STIL_ASSERT_CLK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// block clock and reset
`define STIL_ASSERT(lbl, prop, msg) \
   `STIL_ASSERT_CLK(lbl, clock, reset, prop, msg)

`else

`define STIL_ASSERT_CLK(lbl, clk, rst, prop, msg)
`define STIL_ASSERT(lbl, prop, msg)

`endif

`endif

### src/stil_pkg.sv
// ----------------------------------------------------------------------------
// stil_pkg
// Types and constants for the sorted table interpolating lookup core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stil_pkg;

   localparam int TABLE_DEPTH   = 4096;
   localparam int ADDR_W        = $clog2(TABLE_DEPTH);
   localparam int ENTRY_COUNT_W = 13;
   localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);

   localparam int DATA_W  = 32;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;

   localparam int DIV_STEPS = 32;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAT_SCALE  = 2'd1;

   localparam logic [31:0] HEAT_SCALE_RESET = 32'h0001_0000;
   localparam logic [63:0] HEATING_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] HEATING_MIN      = 64'h8000_0000_0000_0000;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'h0000_0000_8000_0000);

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [11:0]        entry_index;
      logic [31:0]        radius;
      logic signed [31:0] rate;
      logic [31:0]        density;
   } req_type;

   typedef struct packed {
      logic signed [63:0] heating;
      logic               out_of_range;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_KEY_LAST,
      ST_KEY_FIRST,
      ST_CHECK,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_PAIR_LO_RD,
      ST_PAIR_HI_RD,
      ST_PAIR_EVAL,
      ST_DIV,
      ST_MUL_T,
      ST_RATE,
      ST_MUL_MAG,
      ST_SCL_LO,
      ST_SCL_HI,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

### src/stil_ram.sv
// ----------------------------------------------------------------------------
// stil_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stil_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

### src/stil_div.sv
// ----------------------------------------------------------------------------
// stil_div
// Restoring divider for the interpolation fraction, one quotient bit a cycle.
// Requires dividend below divisor; returns floor(dividend * 2^32 / divisor).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module stil_div
   import stil_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output div_status_type   status,
   output logic [31:0]      quotient
);

   logic                 run_ff, run_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic [31:0]          quo_ff, quo_in;

   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   assign shifted = {rem_ff, 1'b0};
   assign ge      = shifted >= {1'b0, dvs_ff};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         rem_in = dividend;
         dvs_in = divisor;
         quo_in = '0;
      end else if (run_ff) begin
         rem_in = ge ? diff[31:0] : shifted[31:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff - DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign status.busy = run_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

   `STIL_ASSERT(a_div_done_idle, (done_ff |-> !run_ff), "divider done while running")
   `STIL_ASSERT(a_div_cnt_live, (run_ff |-> cnt_ff != '0), "divider running with no steps")
   `STIL_ASSERT(a_div_no_restart, (start |-> !run_ff), "divider started while busy")

endmodule

`default_nettype wire

### src/stil_mul.sv
// ----------------------------------------------------------------------------
// stil_mul
// Shared signed 33 x 33 multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stil_mul
   import stil_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic signed [MUL_W-1:0]  a_op,
   input  wire logic signed [MUL_W-1:0]  b_op,
   output logic signed      [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a_op * b_op;
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

### src/sorted_table_interp_lookup_core.sv
// ----------------------------------------------------------------------------
// sorted_table_interp_lookup_core
// A load gives no result; busy stays low.
// A query with fewer than two entries answers in the cycle after start; one
// outside the table answers after ST_KEY_LAST, ST_KEY_FIRST and ST_CHECK;
// otherwise the answer waits on the key RAM search reads and the 32-step
// divider. Flat intervals and a radius on the upper key skip the divider.
// No stall.
// Synchronous reset clears state, strobe and CSRs; data and table are kept.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module sorted_table_interp_lookup_core
   import stil_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_data,
   output logic                      rsp_strobe,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata
);

   state_type state_ff, state_in;

   logic [ENTRY_COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [31:0]              heat_scale_ff, heat_scale_in;

   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic [31:0]       radius_ff, radius_in;
   logic [31:0]       dens_ff, dens_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] lo_ff, lo_in;
   logic [ADDR_W-1:0] hi_ff, hi_in;
   logic [31:0]       key_last_ff, key_last_in;
   logic [31:0]       klo_ff, klo_in;
   logic [31:0]       rlo_ff, rlo_in;
   logic [MUL_W-1:0]  diff_ff, diff_in;
   logic [31:0]       rate_ff, rate_in;
   logic [31:0]       mag_hi_ff, mag_hi_in;
   logic [63:0]       a_ff, a_in;

   logic              accept;
   logic              is_query;
   logic [CNT_W-1:0]  cnt_n;
   logic              short_tbl;
   logic [ADDR_W-1:0] last_addr;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_addr;
   logic [31:0]       key_rd, rate_rd;

   logic              outside;
   logic              go_left;
   logic [ADDR_W-1:0] cur_lo, cur_hi;
   logic [ADDR_W:0]   mid_sum;
   logic [ADDR_W-1:0] nxt_mid;
   logic              srch_done;

   logic              flat;
   logic              direct;
   logic [31:0]       dr, off, off_c;
   logic [MUL_W-1:0]  diff;

   logic              div_start;
   div_status_type    div_status;
   logic [31:0]       quotient;

   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod;

   logic [PROD_W-1:0] wsum;
   logic [31:0]       rate_mag;
   logic              sat;
   logic [63:0]       m_sum;
   logic [63:0]       fin_heating;

   // ---------------------------------------------------------------- config
   always_comb begin
      entry_count_in = entry_count_ff;
      heat_scale_in  = heat_scale_ff;
      if (csr_we && csr_index == CSR_ENTRY_COUNT) begin
         entry_count_in = csr_wdata[ENTRY_COUNT_W-1:0];
      end
      if (csr_we && csr_index == CSR_HEAT_SCALE) begin
         heat_scale_in = csr_wdata;
      end
   end

   // ---------------------------------------------------------------- request
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign is_query  = (req_data.op == OP_QUERY);
   assign cnt_n     = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                               : CNT_W'(entry_count_ff);
   assign short_tbl = cnt_n < CNT_W'(2);
   assign last_addr = ADDR_W'(cnt_n - CNT_W'(1));

   assign ram_we   = accept && !is_query &&
                     (32'(req_data.entry_index) < 32'(TABLE_DEPTH));
   assign ram_addr = busy ? addr_ff : ADDR_W'(req_data.entry_index);

   stil_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_data.radius),
      .rdata (key_rd)
   );

   stil_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_rate_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_data.rate),
      .rdata (rate_rd)
   );

   // ---------------------------------------------------------------- search
   assign outside = (radius_ff > key_last_ff) || (radius_ff < key_rd);
   assign go_left = (radius_ff <= key_rd);

   always_comb begin
      if (state_ff == ST_CHECK) begin
         cur_lo = '0;
         cur_hi = last_addr;
      end else begin
         cur_lo = go_left ? lo_ff : addr_ff;
         cur_hi = go_left ? addr_ff : hi_ff;
      end
   end

   assign mid_sum   = {1'b0, cur_lo} + {1'b0, cur_hi};
   assign nxt_mid   = mid_sum[ADDR_W:1];
   assign srch_done = (({1'b0, cur_lo} + (ADDR_W+1)'(1)) == {1'b0, cur_hi});

   // ---------------------------------------------------------------- interval
   assign flat   = (key_rd <= klo_ff);
   assign dr     = key_rd - klo_ff;
   assign off    = (radius_ff <= klo_ff) ? 32'd0 : (radius_ff - klo_ff);
   assign off_c  = (off > dr) ? dr : off;
   assign direct = flat || (off_c == dr);
   assign diff   = {rate_rd[31], rate_rd} - {rlo_ff[31], rlo_ff};

   assign div_start = (state_ff == ST_PAIR_EVAL) && !direct;

   stil_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (off_c),
      .divisor  (dr),
      .status   (div_status),
      .quotient (quotient)
   );

   stil_mul u_mul (
      .clock (clock),
      .a_op  (mul_a),
      .b_op  (mul_b),
      .prod  (prod)
   );

   // ---------------------------------------------------------------- arithmetic
   assign wsum     = {{2{rlo_ff[31]}}, rlo_ff, 32'h0} + prod + ROUND_HALF;
   assign rate_mag = rate_ff[31] ? (~rate_ff + 32'd1) : rate_ff;
   assign sat      = |prod[63:47];
   assign m_sum    = {prod[47:0], 16'h0} + {16'h0, a_ff[63:16]};

   always_comb begin
      if (rate_ff[31]) begin
         if (sat || m_sum[63]) begin
            fin_heating = HEATING_MIN;
         end else begin
            fin_heating = 64'd0 - m_sum;
         end
      end else begin
         if (sat || m_sum[63]) begin
            fin_heating = HEATING_MAX;
         end else begin
            fin_heating = m_sum;
         end
      end
   end

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query && !short_tbl) begin
               state_in = ST_KEY_LAST;
            end
         end
         ST_KEY_LAST:  state_in = ST_KEY_FIRST;
         ST_KEY_FIRST: state_in = ST_CHECK;
         ST_CHECK: begin
            if (outside) begin
               state_in = ST_IDLE;
            end else if (srch_done) begin
               state_in = ST_PAIR_LO_RD;
            end else begin
               state_in = ST_SRCH_RD;
            end
         end
         ST_SRCH_RD: state_in = ST_SRCH_CMP;
         ST_SRCH_CMP: begin
            state_in = srch_done ? ST_PAIR_LO_RD : ST_SRCH_RD;
         end
         ST_PAIR_LO_RD: state_in = ST_PAIR_HI_RD;
         ST_PAIR_HI_RD: state_in = ST_PAIR_EVAL;
         ST_PAIR_EVAL: begin
            state_in = direct ? ST_MUL_MAG : ST_DIV;
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_MUL_T;
            end
         end
         ST_MUL_T:   state_in = ST_RATE;
         ST_RATE:    state_in = ST_MUL_MAG;
         ST_MUL_MAG: state_in = ST_SCL_LO;
         ST_SCL_LO:  state_in = ST_SCL_HI;
         ST_SCL_HI:  state_in = ST_FINISH;
         ST_FINISH:  state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      radius_in     = radius_ff;
      dens_in       = dens_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      key_last_in   = key_last_ff;
      klo_in        = klo_ff;
      rlo_in        = rlo_ff;
      diff_in       = diff_ff;
      rate_in       = rate_ff;
      mag_hi_in     = mag_hi_ff;
      a_in          = a_ff;
      mul_a         = '0;
      mul_b         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               radius_in = req_data.radius;
               dens_in   = req_data.density;
               addr_in   = last_addr;
               if (short_tbl) begin
                  rsp_strobe_in            = 1'b1;
                  rsp_data_in.heating      = '0;
                  rsp_data_in.out_of_range = 1'b1;
               end
            end
         end
         ST_KEY_LAST: begin
            addr_in = '0;
         end
         ST_KEY_FIRST: begin
            key_last_in = key_rd;
         end
         ST_CHECK, ST_SRCH_CMP: begin
            if (state_ff == ST_CHECK && outside) begin
               rsp_strobe_in            = 1'b1;
               rsp_data_in.heating      = '0;
               rsp_data_in.out_of_range = 1'b1;
            end else begin
               lo_in   = cur_lo;
               hi_in   = cur_hi;
               // probe the midpoint, or fetch the lower entry once bracketed
               addr_in = srch_done ? cur_lo : nxt_mid;
            end
         end
         ST_PAIR_LO_RD: begin
            addr_in = hi_ff;
         end
         ST_PAIR_HI_RD: begin
            klo_in = key_rd;
            rlo_in = rate_rd;
         end
         ST_PAIR_EVAL: begin
            if (direct) begin
               rate_in = rate_rd;
            end else begin
               diff_in = diff;
            end
         end
         ST_MUL_T: begin
            mul_a = diff_ff;
            mul_b = {1'b0, quotient};
         end
         ST_RATE: begin
            rate_in = wsum[63:32];
         end
         ST_MUL_MAG: begin
            mul_a = {1'b0, rate_mag};
            mul_b = {1'b0, dens_ff};
         end
         ST_SCL_LO: begin
            mag_hi_in = prod[63:32];
            mul_a     = {1'b0, prod[31:0]};
            mul_b     = {1'b0, heat_scale_ff};
         end
         ST_SCL_HI: begin
            a_in  = prod[63:0];
            mul_a = {1'b0, mag_hi_ff};
            mul_b = {1'b0, heat_scale_ff};
         end
         ST_FINISH: begin
            rsp_strobe_in            = 1'b1;
            rsp_data_in.heating      = fin_heating;
            rsp_data_in.out_of_range = 1'b0;
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_strobe_ff  <= 1'b0;
         entry_count_ff <= '0;
         heat_scale_ff  <= HEAT_SCALE_RESET;
      end else begin
         state_ff       <= state_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         entry_count_ff <= entry_count_in;
         heat_scale_ff  <= heat_scale_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      radius_ff   <= radius_in;
      dens_ff     <= dens_in;
      addr_ff     <= addr_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      key_last_ff <= key_last_in;
      klo_ff      <= klo_in;
      rlo_ff      <= rlo_in;
      diff_ff     <= diff_in;
      rate_ff     <= rate_in;
      mag_hi_ff   <= mag_hi_in;
      a_ff        <= a_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   `STIL_ASSERT(a_oor_zero, (rsp_strobe |-> (!rsp_data.out_of_range || rsp_data.heating == '0)), "out of range result is not zero")
   `STIL_ASSERT(a_rsp_cause, (rsp_strobe |-> ($past(busy) || $past(start))), "result without a query")
   `STIL_ASSERT(a_srch_open, ((state_ff == ST_SRCH_CMP) |-> (({1'b0, lo_ff} + (ADDR_W+1)'(1)) < {1'b0, hi_ff})), "search probe on a closed interval")
   `STIL_ASSERT(a_div_live, ((state_ff == ST_DIV) |-> (div_status.busy || div_status.done)), "waiting on an idle divider")

endmodule

`default_nettype wire

### bench/heating_lookup_monitor.sv
// ----------------------------------------------------------------------------
// heating_lookup_monitor
// Watches the request, result and register ports of the lookup core, keeps
// its own copy of the table and registers, predicts the heating of every
// accepted query and compares each result strobe with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module heating_lookup_monitor
   import stil_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic                 busy,
   input  wire req_type              req_data,
   input  wire logic                 rsp_strobe,
   input  wire rsp_type              rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_wdata,
   output int                        mismatch_count,
   output int                        heating_pending
);

   logic [31:0]              radius_key [TABLE_DEPTH];
   logic signed [31:0]       rate_entry [TABLE_DEPTH];
   logic [ENTRY_COUNT_W-1:0] entry_count;
   logic [31:0]              heat_scale;
   rsp_type                  heating_due [$];
   int                       fault_total = 0;

   function automatic rsp_type interpolated_heating(input logic [31:0] radius,
                                                     input logic [31:0] density);
      rsp_type     res;
      int          span, lo, hi, mid;
      logic [31:0] key_lo, key_hi, key_gap, radius_gap;
      logic [63:0] span_gap, offset, frac, mag, part_lo, part_hi, total;
      longint      rate_lo, rate_hi, wsum, rate_q;
      logic        neg;
      res.heating      = '0;
      res.out_of_range = 1'b1;
      span = (int'(entry_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
      if (span < 2)
         return res;
      if (radius > radius_key[span-1] || radius < radius_key[0])
         return res;
      lo = 0;
      hi = span - 1;
      while (lo + 1 != hi) begin
         mid = (lo + hi) / 2;
         if (radius <= radius_key[mid])
            hi = mid;
         else
            lo = mid;
      end
      key_lo  = radius_key[lo];
      key_hi  = radius_key[hi];
      rate_lo = rate_entry[lo];
      rate_hi = rate_entry[hi];
      if (key_hi <= key_lo) begin
         rate_q = rate_hi;
      end else begin
         key_gap    = key_hi - key_lo;
         radius_gap = radius - key_lo;
         span_gap   = 64'(key_gap);
         offset     = (radius <= key_lo) ? 64'd0 : 64'(radius_gap);
         if (offset > span_gap)
            offset = span_gap;
         // Q0.32 weight of the upper entry, truncated
         frac   = (offset << 32) / span_gap;
         wsum   = rate_lo * longint'(64'h1_0000_0000 - frac) + rate_hi * longint'(frac);
         rate_q = (wsum + 64'sh8000_0000) >>> 32;
      end
      neg     = rate_q < 0;
      mag     = neg ? 64'(-rate_q) : 64'(rate_q);
      mag     = mag * 64'(density);
      part_lo = 64'(mag[31:0]) * 64'(heat_scale);
      part_hi = 64'(mag[63:32]) * 64'(heat_scale);
      if (part_hi >= 64'h0000_8000_0000_0000) begin
         res.heating = neg ? HEATING_MIN : HEATING_MAX;
      end else begin
         total = (part_hi << 16) + (part_lo >> 16);
         if (neg)
            res.heating = (total >= HEATING_MIN) ? HEATING_MIN : -total;
         else
            res.heating = (total > HEATING_MAX) ? HEATING_MAX : total;
      end
      res.out_of_range = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         entry_count = '0;
         heat_scale  = HEAT_SCALE_RESET;
         heating_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ENTRY_COUNT: entry_count = csr_wdata[ENTRY_COUNT_W-1:0];
               CSR_HEAT_SCALE:  heat_scale  = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_data.op == OP_LOAD) begin
               radius_key[req_data.entry_index] = req_data.radius;
               rate_entry[req_data.entry_index] = req_data.rate;
            end else begin
               heating_due.push_back(interpolated_heating(req_data.radius,
                                                          req_data.density));
            end
         end
         if (rsp_strobe) begin
            if (heating_due.size() == 0) begin
               fault_total++;
               if (fault_total <= 10)
                  $display("unexpected heating result %h out_of_range %b",
                           rsp_data.heating, rsp_data.out_of_range);
            end else begin
               want = heating_due.pop_front();
               if (rsp_data.heating !== want.heating ||
                   rsp_data.out_of_range !== want.out_of_range) begin
                  fault_total++;
                  if (fault_total <= 10)
                     $display("heating mismatch: expected %h oor %b, got %h oor %b",
                              want.heating, want.out_of_range,
                              rsp_data.heating, rsp_data.out_of_range);
               end
            end
         end
      end
      heating_pending <= heating_due.size();
      mismatch_count  <= fault_total;
   end

endmodule

### bench/sorted_table_interp_lookup_core_test.sv
// ----------------------------------------------------------------------------
// sorted_table_interp_lookup_core_test
// Loads heating tables into the lookup core and queries them: a directed
// pass over the special cases, a full-depth table, then random phases with
// new entry counts and scales, mostly in-table radii and random idle bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_table_interp_lookup_core_test;
   import stil_pkg::*;

   localparam int LIMIT_CYCLES  = 3_000_000;
   localparam int SETTLE_CYCLES = 90;
   localparam int RANDOM_ITEMS  = 1200;
   localparam int CALM_ITEMS    = 150;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_B = 2'd3;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_data = '0;
   logic                 rsp_strobe;
   rsp_type              rsp_data;
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0]          csr_wdata = '0;
   int                   mismatch_count;
   int                   heating_pending;
   int                   cycle_count = 0;

   logic [31:0] key_map [TABLE_DEPTH];
   int          items_sent = 0;
   int          span_now = 0;
   bit          gaps_on = 1'b0;

   sorted_table_interp_lookup_core u_top (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   heating_lookup_monitor u_monitor (
      .clock, .reset, .start, .busy, .req_data, .rsp_strobe, .rsp_data,
      .csr_we, .csr_index, .csr_wdata, .mismatch_count, .heating_pending
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic logic [31:0] spread_value();
      return $urandom >> $urandom_range(0, 31);
   endfunction

   function automatic logic [31:0] spread_rate();
      logic [31:0] mag;
      case ($urandom_range(0, 15))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         default: begin
            mag = spread_value();
            return $urandom_range(0, 1) ? -mag : mag;
         end
      endcase
   endfunction

   function automatic req_type load_item(input logic [11:0] index, input logic [31:0] key,
                                         input logic [31:0] rate);
      req_type item;
      item.op          = OP_LOAD;
      item.entry_index = index;
      item.radius      = key;
      item.rate        = rate;
      item.density     = $urandom;
      return item;
   endfunction

   function automatic req_type query_item(input logic [31:0] radius,
                                          input logic [31:0] density);
      req_type item;
      item.op          = OP_QUERY;
      item.entry_index = 12'($urandom);
      item.radius      = radius;
      item.rate        = $urandom;
      item.density     = density;
      return item;
   endfunction

   // mostly inside a bracketing interval, some at or just past the ends, some random
   function automatic logic [31:0] pick_radius();
      int          sel, i;
      logic [31:0] lo_key, hi_key;
      sel = $urandom_range(0, 99);
      if (span_now < 2 || sel < 10)
         return $urandom;
      if (sel < 25) begin
         case ($urandom_range(0, 3))
            0: return key_map[0];
            1: return key_map[span_now-1];
            2: return key_map[0] - 1;
            default: return key_map[span_now-1] + 1;
         endcase
      end
      i      = $urandom_range(0, span_now - 2);
      lo_key = key_map[i];
      hi_key = key_map[i+1];
      if (hi_key <= lo_key || sel < 35)
         return (sel & 1) ? hi_key : lo_key;
      return lo_key + $urandom_range(0, hi_key - lo_key);
   endfunction

   task automatic send_item(input req_type item);
      if (gaps_on && $urandom_range(0, 99) < 15) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_data <= item;
      start    <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (item.op == OP_LOAD)
         key_map[item.entry_index] = item.radius;
   endtask

   // drop start, drain all queries, then cover a query still in flight
   task automatic settle();
      start <= 1'b0;
      while (heating_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == CSR_ENTRY_COUNT)
         span_now = (int'(value[ENTRY_COUNT_W-1:0]) > TABLE_DEPTH) ?
                    TABLE_DEPTH : int'(value[ENTRY_COUNT_W-1:0]);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // rewrite the front of the table as a mostly ascending run that stays below
   // the first entry kept from the previous contents unless a step down wraps
   task automatic rebuild_front(input int span);
      int          fill, sel;
      logic [31:0] ceiling, key, step_max;
      fill = (span < 64) ? span : 64;
      if (fill == 0)
         return;
      ceiling  = (span > fill) ? key_map[fill] : 32'hFFFF_FFFF;
      key      = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(0, ceiling / 4);
      step_max = (ceiling - key) / fill;
      for (int i = 0; i < fill; i++) begin
         send_item(load_item(12'(i), key, spread_rate()));
         sel = $urandom_range(0, 99);
         if (sel < 6)
            key = key;
         else if (sel < 9)
            key = key - $urandom_range(0, step_max);
         else
            key = key + $urandom_range(0, step_max);
      end
   endtask

   initial begin
      int          target, count, sel, batch;
      logic [31:0] key, scale, wdata;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // short table: empty, then a single entry
      send_item(query_item(32'h0001_0000, 32'h0001_0000));
      settle();
      write_csr(CSR_ENTRY_COUNT, 32'd1);
      send_item(load_item(12'd0, 32'h0001_0000, 32'h0002_0000));
      send_item(query_item(32'h0001_0000, 32'h0001_0000));
      // flat pair at the bottom, a descending pair, extreme rates and keys
      send_item(load_item(12'd1, 32'h0001_0000, 32'hFFFF_0000));
      send_item(load_item(12'd2, 32'h0003_0000, 32'h7FFF_FFFF));
      send_item(load_item(12'd3, 32'h0008_0000, 32'h8000_0000));
      send_item(load_item(12'd4, 32'h0006_0000, 32'h0000_8000));
      send_item(load_item(12'd5, 32'h0010_0000, 32'h0000_0000));
      send_item(load_item(12'd6, 32'h8000_0000, 32'h0001_0000));
      send_item(load_item(12'd7, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
      settle();
      write_csr(CSR_ENTRY_COUNT, 32'd8);
      send_item(query_item(32'h0000_0000, 32'h0001_0000));
      send_item(query_item(32'h0001_0000, 32'h0001_0000));
      send_item(query_item(32'h0002_0000, 32'h0001_0000));
      send_item(query_item(32'h0005_0000, 32'hFFFF_FFFF));
      send_item(query_item(32'h000C_0000, 32'h0001_0000));
      send_item(query_item(32'hC000_0000, 32'h0001_0000));
      send_item(query_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      settle();
      // saturate both ways
      write_csr(CSR_HEAT_SCALE, 32'hFFFF_FFFF);
      send_item(query_item(32'hFFFF_FFFF, 32'hFFFF_FFFF));
      send_item(query_item(32'h0008_0000, 32'hFFFF_FFFF));
      settle();
      write_csr(CSR_HEAT_SCALE, 32'd0);
      send_item(query_item(32'h0002_0000, 32'hFFFF_FFFF));
      settle();
      // unmapped registers must leave the scale alone
      write_csr(CSR_HEAT_SCALE, HEAT_SCALE_RESET);
      write_csr(CSR_UNMAPPED_A, 32'hFFFF_FFFF);
      write_csr(CSR_UNMAPPED_B, 32'h0000_0000);
      send_item(query_item(32'h0002_0000, 32'h0001_0000));
      settle();

      // fill every slot with an ascending run, occasional flat steps
      gaps_on = 1'b1;
      key = $urandom_range(0, 255);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         send_item(load_item(12'(i), key, spread_rate()));
         if ($urandom_range(0, 19) != 0)
            key = key + $urandom_range(1, 32'h0007_FFFF);
      end
      foreach (key_map[i]) begin
         if (i == 0) begin
            settle();
            write_csr(CSR_ENTRY_COUNT, TABLE_DEPTH);
         end else if (i == 1) begin
            settle();
            write_csr(CSR_ENTRY_COUNT, 32'h0000_1FFF);
         end else begin
            break;
         end
         repeat (50) send_item(query_item(pick_radius(), spread_value()));
      end

      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         settle();
         sel = $urandom_range(0, 99);
         if (sel < 8)
            count = $urandom_range(0, 1);
         else if (sel < 65)
            count = $urandom_range(2, 24);
         else if (sel < 82)
            count = $urandom_range(25, 300);
         else if (sel < 95)
            count = $urandom_range(301, TABLE_DEPTH);
         else
            count = $urandom_range(TABLE_DEPTH + 1, 8191);
         wdata = 32'(count);
         if ($urandom_range(0, 1))
            wdata = wdata | ($urandom & 32'hFFFF_E000);
         write_csr(CSR_ENTRY_COUNT, wdata);
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 5))
               0: scale = 32'd0;
               1: scale = 32'hFFFF_FFFF;
               2: scale = HEAT_SCALE_RESET;
               default: scale = spread_value();
            endcase
            write_csr(CSR_HEAT_SCALE, scale);
         end
         if ($urandom_range(0, 9) == 0)
            write_csr($urandom_range(0, 1) ? CSR_UNMAPPED_A : CSR_UNMAPPED_B, $urandom);
         gaps_on = (items_sent < target - CALM_ITEMS) && ($urandom_range(0, 2) != 0);
         if ($urandom_range(0, 9) < 7)
            rebuild_front(span_now);
         batch = $urandom_range(10, 60);
         repeat (batch) begin
            // quiet sender for the closing stretch
            if (items_sent >= target - CALM_ITEMS)
               gaps_on = 1'b0;
            if ($urandom_range(0, 99) < 8)
               send_item(load_item(12'($urandom), $urandom, spread_rate()));
            else
               send_item(query_item(pick_radius(), spread_value()));
         end
      end

      settle();
      if (mismatch_count == 0 && heating_pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
